[rtl/mhp_pkg.sv]
// Package for the 802.15.4 MAC header parser: status and addressing mode codes,
// header field lengths and the header report record.
// No dependencies.
package mhp_pkg;

	// Report status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNC     = 3'd1,
		ST_DEST_RSVD = 3'd2,
		ST_SRC_RSVD  = 3'd3,
		ST_NO_DEST   = 3'd4
	} status_t;

	// Addressing mode codes from the frame control word.
	typedef enum logic [1:0] {
		AM_NONE  = 2'd0,
		AM_RSVD  = 2'd1,
		AM_SHORT = 2'd2,
		AM_LONG  = 2'd3
	} addr_mode_t;

	// Byte positions and field lengths, in bytes.
	localparam logic [4:0] POS_FC_HI = 5'd1;
	localparam logic [4:0] POS_SEQ   = 5'd2;
	localparam logic [4:0] FIXED_LEN = 5'd3;
	localparam logic [4:0] PAN_LEN   = 5'd2;
	localparam logic [4:0] SHORT_LEN = 5'd2;
	localparam logic [4:0] LONG_LEN  = 5'd8;

	// One header report as it waits in the output buffer.
	typedef struct packed {
		status_t     status;
		logic [2:0]  frame_type;
		logic [7:0]  seq_num;
		logic [1:0]  dest_mode;
		logic [15:0] dest_pan;
		logic [63:0] dest_addr;
		logic [1:0]  src_mode;
		logic [15:0] src_pan;
		logic [63:0] src_addr;
		logic [4:0]  header_len;
	} report_t;

endpackage

[rtl/mhp_byte_if.sv]
// Byte channel of the MAC header parser: one frame byte and its last-byte mark per word.
// No dependencies.
interface mhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, output in_byte, output in_last, input ready);
	modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/mhp_report_if.sv]
// Report channel of the MAC header parser: one parsed header report per word.
// No dependencies.
interface mhp_report_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  frame_type;
	logic [7:0]  seq_num;
	logic [1:0]  dest_mode;
	logic [15:0] dest_pan;
	logic [63:0] dest_addr;
	logic [1:0]  src_mode;
	logic [15:0] src_pan;
	logic [63:0] src_addr;
	logic [4:0]  header_len;

	modport source(output valid, output status, output frame_type, output seq_num,
		output dest_mode, output dest_pan, output dest_addr, output src_mode,
		output src_pan, output src_addr, output header_len, input ready);
	modport sink(input valid, input status, input frame_type, input seq_num,
		input dest_mode, input dest_pan, input dest_addr, input src_mode,
		input src_pan, input src_addr, input header_len, output ready);
endinterface

[rtl/ieee802154_mac_header_parser.sv]
// IEEE 802.15.4 MAC header parser, top level.
// Depends on mhp_pkg, mhp_byte_if and mhp_report_if.
//
//   channel  interface      dir  word contents
//   -------  -------------  ---  ----------------------------------------------
//   frame    mhp_byte_if    in   in_byte, in_last (last byte of the frame)
//   report   mhp_report_if  out  status, frame_type, seq_num, modes, PANs,
//                                addresses, header_len
//
// One byte is taken per cycle while frame.ready is high; each byte up to the report
// updates the header registers, and a report it completes is written into the output buffer.
// Reports wait in a two-word output buffer; frame.ready drops only while both
// words are full, so bytes keep flowing while one report waits to be taken.
// arst_n clears the header registers and empties the output buffer.
// All header state is cleared again after the last byte of every frame.
module ieee802154_mac_header_parser (
	input logic           clk,
	input logic           arst_n,
	mhp_byte_if.sink      frame,
	mhp_report_if.source  report
);
	import mhp_pkg::*;

	// Header registers.
	logic [4:0]  pos_q;
	logic [15:0] fc_q;
	logic [7:0]  seq_q;
	logic [15:0] dpan_q;
	logic [63:0] daddr_q;
	logic [15:0] span_q;
	logic [63:0] saddr_q;
	logic        done_q;

	// Updated values for the current byte.
	logic [4:0]  n;
	logic [15:0] fc_n;
	logic [7:0]  seq_n;
	logic [15:0] dpan_n;
	logic [63:0] daddr_n;
	logic [15:0] span_n;
	logic [63:0] saddr_n;
	logic [1:0]  dm;
	logic [1:0]  sm;
	logic        comp;
	logic [4:0]  e1, e2, e3, e4;
	logic [2:0]  lane;
	logic        rep;
	status_t     st;
	logic [4:0]  hl;
	report_t     rpt_n;

	// Output buffer.
	report_t     buf_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        push;
	logic        pop;
	report_t     rpt;

	assign accept = frame.valid && frame.ready;
	assign push   = accept && !done_q && rep;
	assign pop    = report.valid && report.ready;

	// Field update for the incoming byte and field boundaries.
	always_comb begin
		fc_n    = fc_q;
		seq_n   = seq_q;
		dpan_n  = dpan_q;
		daddr_n = daddr_q;
		span_n  = span_q;
		saddr_n = saddr_q;
		lane    = '0;
		n       = pos_q + 5'd1;

		if (pos_q == '0) begin
			fc_n[7:0] = frame.in_byte;
		end else if (pos_q == POS_FC_HI) begin
			fc_n[15:8] = frame.in_byte;
		end

		// Once the frame control word is in, the boundaries follow from it.
		dm   = fc_n[11:10];
		sm   = fc_n[15:14];
		comp = fc_n[6];
		e1   = FIXED_LEN + (dm[1] ? PAN_LEN : 5'd0);
		e2   = e1 + ((dm == AM_SHORT) ? SHORT_LEN : ((dm == AM_LONG) ? LONG_LEN : 5'd0));
		e3   = e2 + ((sm[1] && !comp) ? PAN_LEN : 5'd0);
		e4   = e3 + ((sm == AM_SHORT) ? SHORT_LEN : ((sm == AM_LONG) ? LONG_LEN : 5'd0));

		priority if (pos_q < POS_SEQ) begin
			// Frame control byte, handled above.
		end else if (pos_q == POS_SEQ) begin
			seq_n = frame.in_byte;
		end else if (pos_q < e1) begin
			if (pos_q[0]) begin
				dpan_n[7:0] = frame.in_byte;
			end else begin
				dpan_n[15:8] = frame.in_byte;
			end
		end else if (pos_q < e2) begin
			lane = pos_q[2:0] - e1[2:0];
			daddr_n[8*lane +: 8] = frame.in_byte;
		end else if (pos_q < e3) begin
			if (pos_q[0] ^ e2[0]) begin
				span_n[15:8] = frame.in_byte;
			end else begin
				span_n[7:0] = frame.in_byte;
			end
		end else if (pos_q < e4) begin
			lane = pos_q[2:0] - e3[2:0];
			saddr_n[8*lane +: 8] = frame.in_byte;
		end else begin
			// Past the header fields: nothing is stored.
		end
	end

	// Report decision and contents.
	always_comb begin
		rep = 1'b0;
		st  = ST_OK;
		hl  = '0;
		if (n >= FIXED_LEN) begin
			priority if (dm == AM_NONE && comp) begin
				rep = 1'b1;
				st  = ST_NO_DEST;
				hl  = FIXED_LEN;
			end else if (dm == AM_RSVD) begin
				rep = 1'b1;
				st  = ST_DEST_RSVD;
				hl  = FIXED_LEN;
			end else if (sm == AM_RSVD && n == e2) begin
				rep = 1'b1;
				st  = ST_SRC_RSVD;
				hl  = '0;
			end else if (sm != AM_RSVD && n == e4) begin
				rep = 1'b1;
				st  = ST_OK;
				hl  = e4;
			end else if (frame.in_last) begin
				rep = 1'b1;
				st  = ST_TRUNC;
				if (e4 <= n) begin
					hl = e4;
				end else if (e3 <= n) begin
					hl = e3;
				end else if (e2 <= n) begin
					hl = e2;
				end else if (e1 <= n) begin
					hl = e1;
				end else begin
					hl = FIXED_LEN;
				end
			end else begin
				// Header still in progress: no report yet.
			end
		end else if (frame.in_last) begin
			rep = 1'b1;
			st  = ST_TRUNC;
			hl  = n;
		end

		rpt_n.status     = st;
		rpt_n.frame_type = fc_n[2:0];
		rpt_n.seq_num    = (n >= FIXED_LEN) ? seq_n : '0;
		rpt_n.dest_mode  = dm;
		rpt_n.dest_pan   = (dm[1] && n >= e1) ? dpan_n : '0;
		rpt_n.dest_addr  = (dm[1] && n >= e2) ? daddr_n : '0;
		rpt_n.src_mode   = sm;
		rpt_n.src_pan    = (sm[1] && st != ST_SRC_RSVD && n >= e3 && n >= FIXED_LEN)
			? (comp ? dpan_n : span_n) : '0;
		rpt_n.src_addr   = (sm[1] && n >= e4 && n >= FIXED_LEN) ? saddr_n : '0;
		rpt_n.header_len = hl;
	end

	// Header registers: cleared after the last byte, frozen once reported.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fc_q    <= '0;
			seq_q   <= '0;
			dpan_q  <= '0;
			daddr_q <= '0;
			span_q  <= '0;
			saddr_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			if (frame.in_last) begin
				pos_q   <= '0;
				fc_q    <= '0;
				seq_q   <= '0;
				dpan_q  <= '0;
				daddr_q <= '0;
				span_q  <= '0;
				saddr_q <= '0;
				done_q  <= 1'b0;
			end else if (!done_q) begin
				pos_q   <= n;
				fc_q    <= fc_n;
				seq_q   <= seq_n;
				dpan_q  <= dpan_n;
				daddr_q <= daddr_n;
				span_q  <= span_n;
				saddr_q <= saddr_n;
				done_q  <= rep;
			end
		end
	end

	// Output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Output buffer words.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= rpt_n;
		end
	end

	// Channel outputs.
	assign frame.ready       = (cnt_q != 2'd2);
	assign report.valid      = (cnt_q != 2'd0);
	assign rpt               = buf_q[rd_ptr_q];
	assign report.status     = rpt.status;
	assign report.frame_type = rpt.frame_type;
	assign report.seq_num    = rpt.seq_num;
	assign report.dest_mode  = rpt.dest_mode;
	assign report.dest_pan   = rpt.dest_pan;
	assign report.dest_addr  = rpt.dest_addr;
	assign report.src_mode   = rpt.src_mode;
	assign report.src_pan    = rpt.src_pan;
	assign report.src_addr   = rpt.src_addr;
	assign report.header_len = rpt.header_len;

	// A frame is only marked reported after at least the fixed header.
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (pos_q >= FIXED_LEN))
		else $error("header marked reported before the fixed header");

	// The last byte of a frame leaves the header registers clear.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame.in_last) |=> (pos_q == '0 && !done_q && fc_q == '0))
		else $error("header state not cleared after the last byte");

	// A complete header reports its own full length.
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		(push && rpt_n.status == ST_OK) |-> (rpt_n.header_len == n))
		else $error("complete header with wrong length");

	// The buffer count goes up by one on a push without a pop.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("output buffer count lost a report");

	// At most one report between two last bytes unless the frame restarted.
	a_one_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !push)
		else $error("second report for one frame");

endmodule
